// File: rtl/urad_pkg.sv
// shared constants and helpers for the unsigned-to-ascii radix converter
package urad_pkg;

	localparam int VALUE_W         = 32;
	localparam int BASE_W          = 6;
	localparam int DIGIT_W         = 6;
	localparam int CHAR_W          = 8;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int MAX_DIGITS_DEF  = 32;

	localparam logic [BASE_W-1:0]  BASE_MIN      = 6'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX      = 6'd36;
	localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
	localparam logic [CHAR_W-1:0]  DIGIT_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0]  LETTER_OFS    = 8'h37;
	localparam logic [CHAR_W-1:0]  BAD_CHAR      = 8'h00;

	// digit value to ascii character
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < DECIMAL_LIMIT) begin
			return DIGIT_ZERO + dx;
		end
		return LETTER_OFS + dx;
	endfunction

endpackage

// File: rtl/urad_if.sv
// handshake channel interfaces for input items and result characters
interface urad_in_if;
	logic                          valid;
	logic                          ready;
	logic [urad_pkg::VALUE_W-1:0]  value;
	logic [urad_pkg::BASE_W-1:0]   base;

	modport source (output valid, output value, output base, input ready);
	modport sink   (input valid, input value, input base, output ready);
endinterface

interface urad_out_if;
	logic                          valid;
	logic                          ready;
	logic [urad_pkg::CHAR_W-1:0]   digit_char;
	logic                          last;
	logic                          bad_base;

	modport source (output valid, output digit_char, output last, output bad_base, input ready);
	modport sink   (input valid, input digit_char, input last, input bad_base, output ready);
endinterface

// File: rtl/unsigned_to_ascii_radix_core.sv
// top level: sequencer, digit store and output register of the radix converter
// each digit takes one pass of the shared bit-serial divider
// (load, VALUE_BITS quotient steps, write-back), then each stored digit is read back and emitted
// throughput is one item at a time; a new item is taken only while the sequencer is idle
// reset: arst_n clears sequencer, counters and output valid; the digit store is not cleared
module unsigned_to_ascii_radix_core #(
	parameter int VALUE_BITS = urad_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = urad_pkg::MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	urad_in_if.sink     item,
	urad_out_if.source  result
);

	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_DIV_START,
		S_DIV_RUN,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [ADDR_W-1:0]              ptr_q;
	logic [VALUE_BITS-1:0]          quot_q;
	logic [urad_pkg::BASE_W-1:0]    base_q;

	// output register
	logic                           out_valid_q;
	logic [urad_pkg::CHAR_W-1:0]    out_char_q;
	logic                           out_last_q;
	logic                           out_bad_q;

	// digit store, no reset: every entry read was written in the same item
	logic [urad_pkg::DIGIT_W-1:0]   store_mem [MAX_DIGITS];
	logic [urad_pkg::DIGIT_W-1:0]   rd_data_q;

	logic                           div_done;
	logic [VALUE_BITS-1:0]          div_quot;
	logic [urad_pkg::DIGIT_W-1:0]   div_rem;

	logic [VALUE_BITS-1:0]          value_m;
	logic                           in_xfer;
	logic                           base_ok;
	logic                           slot_free;
	logic                           store_full;
	logic                           out_load;

	// only the low VALUE_BITS of the value take part
	if (VALUE_BITS <= urad_pkg::VALUE_W) begin : g_trunc
		assign value_m = item.value[VALUE_BITS-1:0];
	end else begin : g_ext
		assign value_m = {{(VALUE_BITS - urad_pkg::VALUE_W){1'b0}}, item.value};
	end

	assign item.ready = (state_q == S_IDLE);
	assign in_xfer    = item.valid && item.ready;
	assign base_ok    = (item.base >= urad_pkg::BASE_MIN) && (item.base <= urad_pkg::BASE_MAX);
	assign slot_free  = !out_valid_q || result.ready;
	assign store_full = (cnt_q == CNT_W'(MAX_DIGITS - 1));
	// a new result enters the output register this cycle
	assign out_load   = slot_free && (state_q == S_ERR || state_q == S_EMIT_LD);

	urad_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_DIV_START),
		.dividend  (quot_q),
		.divisor   (base_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// remainder written at the current digit count, read back from the top down
	always_ff @(posedge clk) begin
		if (state_q == S_DIV_RUN && div_done) begin
			store_mem[cnt_q[ADDR_W-1:0]] <= div_rem;
		end
		rd_data_q <= store_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a taken result frees the slot unless reloaded
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						if (base_ok) begin
							state_q <= S_DIV_START;
						end else begin
							state_q <= S_ERR;
						end
					end
				end
				S_ERR: begin
					// bad base: single flagged result, no digits
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (div_done) begin
						cnt_q <= cnt_q + 1'b1;
						if (div_quot == '0 || store_full) begin
							ptr_q   <= cnt_q[ADDR_W-1:0];
							state_q <= S_EMIT_RD;
						end else begin
							state_q <= S_DIV_START;
						end
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (slot_free) begin
						if (ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the sequencer, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			quot_q <= value_m;
			base_q <= item.base;
		end else if (state_q == S_DIV_RUN && div_done) begin
			quot_q <= div_quot;
		end
		if (state_q == S_ERR && slot_free) begin
			out_char_q <= urad_pkg::BAD_CHAR;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b1;
		end else if (state_q == S_EMIT_LD && slot_free) begin
			out_char_q <= urad_pkg::to_ascii(rd_data_q);
			out_last_q <= (ptr_q == '0);
			out_bad_q  <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.digit_char = out_char_q;
	assign result.last       = out_last_q;
	assign result.bad_base   = out_bad_q;

	// input side only opens while the sequencer is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");

	// an error result always closes its run
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.bad_base) |-> result.last)
		else $error("bad base result without last");

	// divider completes only while the sequencer waits on it
	a_div_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_RUN))
		else $error("divider done outside run state");

	// digit count never exceeds the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond store depth");

	// emission always starts from a filled store
	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_RD) |-> (cnt_q != '0))
		else $error("emission with no digits stored");

endmodule

// File: rtl/urad_div.sv
// restoring bit-serial divider, one quotient bit per cycle
module urad_div #(
	parameter int VALUE_BITS = urad_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_BITS-1:0]         dividend,
	input  logic [urad_pkg::BASE_W-1:0]   divisor,
	output logic                          done,
	output logic [VALUE_BITS-1:0]         quotient,
	output logic [urad_pkg::DIGIT_W-1:0]  remainder
);

	localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [VALUE_BITS-1:0]         q_q;
	logic [urad_pkg::DIGIT_W-1:0]  rem_q;

	logic [urad_pkg::DIGIT_W:0]    trial;
	logic [urad_pkg::DIGIT_W:0]    dvs;
	logic                          ge;

	assign trial = {rem_q, q_q[VALUE_BITS-1]};
	assign dvs   = {1'b0, divisor};
	assign ge    = (trial >= dvs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			q_q   <= {q_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? urad_pkg::DIGIT_W'(trial - dvs) : trial[urad_pkg::DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = rem_q;

endmodule

// File: test/tb_top.sv
// self-checking testbench for the unsigned-to-ascii radix converter
module tb_top;

	localparam int TAIL_CYCLES = urad_pkg::VALUE_BITS_DEF + 8;   // a little over one divider pass
	localparam int MAX_ITEMS   = 68;                  // random numbers in the main test

	// one result character as the receiver sees it
	typedef struct packed {
		logic [urad_pkg::CHAR_W-1:0] digit_char;
		logic                        last;
		logic                        bad_base;
	} radix_char_t;

	logic clk = 1'b0;
	logic arst_n;

	urad_in_if  item_if ();
	urad_out_if result_if ();

	unsigned_to_ascii_radix_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if.sink),
		.result (result_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	radix_char_t pending_chars[$];   // characters still owed by the block, oldest first
	int          mismatches;
	int          numbers_sent;
	int          bad_radix_sent;
	int          chars_checked;
	bit          tx_idle_on;          // sender inserts random gaps
	bit          rx_idle_on;          // receiver drops ready at random
	int unsigned hold_left;           // forced receiver hold-off still to run, in cycles

	// mostly no gap, some short ones, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(12, 60);
	endfunction

	function automatic void report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("tb_top: mismatch: %s", msg);
		end
	endfunction

	// expected characters of one number: repeated division, then most significant first
	function automatic void spell_number(input logic [urad_pkg::VALUE_W-1:0] val,
			input logic [urad_pkg::BASE_W-1:0] radix);
		logic [urad_pkg::DIGIT_W-1:0] digs [urad_pkg::MAX_DIGITS_DEF];
		logic [urad_pkg::VALUE_W-1:0] quo;
		logic [urad_pkg::VALUE_W-1:0] rem;
		int                           n;
		radix_char_t                  c;
		if (radix < urad_pkg::BASE_MIN || radix > urad_pkg::BASE_MAX) begin
			c.digit_char = urad_pkg::BAD_CHAR;
			c.last       = 1'b1;
			c.bad_base   = 1'b1;
			pending_chars.push_back(c);
			return;
		end
		quo = val;
		n   = 0;
		do begin
			rem     = quo % urad_pkg::VALUE_W'(radix);
			quo     = quo / urad_pkg::VALUE_W'(radix);
			digs[n] = rem[urad_pkg::DIGIT_W-1:0];
			n++;
		end while (quo != 0 && n < urad_pkg::MAX_DIGITS_DEF);
		for (int k = n - 1; k >= 0; k--) begin
			if (digs[k] < urad_pkg::DECIMAL_LIMIT) begin
				c.digit_char = urad_pkg::DIGIT_ZERO + urad_pkg::CHAR_W'(digs[k]);
			end else begin
				c.digit_char = urad_pkg::LETTER_OFS + urad_pkg::CHAR_W'(digs[k]);
			end
			c.last     = (k == 0);
			c.bad_base = 1'b0;
			pending_chars.push_back(c);
		end
	endfunction

	// offer one number, hold it until the block takes it, then maybe leave a gap;
	// valid stays high across a zero gap so the next number follows without a hole
	task automatic send_number(input logic [urad_pkg::VALUE_W-1:0] val,
			input logic [urad_pkg::BASE_W-1:0] radix);
		int unsigned gap;
		item_if.valid <= 1'b1;
		item_if.value <= val;
		item_if.base  <= radix;
		do @(posedge clk); while (!item_if.ready);
		spell_number(val, radix);
		numbers_sent++;
		if (radix < urad_pkg::BASE_MIN || radix > urad_pkg::BASE_MAX) begin
			bad_radix_sent++;
		end
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		item_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender stops until every owed character has arrived, then lets the tail pass
	task automatic wait_all_done();
		end_burst();
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic random_number(output logic [urad_pkg::VALUE_W-1:0] val,
			output logic [urad_pkg::BASE_W-1:0] radix);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// bad radix: 0, 1 or 37..63
			r     = $urandom_range(0, 28);
			radix = (r < 2) ? urad_pkg::BASE_W'(r) : urad_pkg::BASE_W'(r + 35);
		end else if (r < 20) begin
			// long digit runs, kept rare since each binary digit costs a full divider pass
			radix = urad_pkg::BASE_W'($urandom_range(2, 4));
		end else begin
			radix = urad_pkg::BASE_W'($urandom_range(5, 36));
		end
		r = $urandom_range(0, 3);
		case (r)
			0: begin
				val = urad_pkg::VALUE_W'($urandom_range(0, 1000));
			end
			1: begin
				val = $urandom >> $urandom_range(0, 31);
			end
			default: begin
				val = $urandom;
			end
		endcase
	endtask

	// zero, one, top of range, smallest and largest radix, letters up to 'Z'
	task automatic test_digit_extremes();
		send_number(32'd0, 6'd10);
		send_number(32'd0, urad_pkg::BASE_MIN);
		send_number(32'd0, urad_pkg::BASE_MAX);
		send_number(32'd1, urad_pkg::BASE_MIN);
		send_number(32'hFFFF_FFFF, urad_pkg::BASE_MIN);
		send_number(32'hFFFF_FFFF, urad_pkg::BASE_MAX);
		send_number(32'hFFFF_FFFF, 6'd10);
		send_number(32'hFFFF_FFFF, 6'd16);
		send_number(32'h8000_0000, urad_pkg::BASE_MIN);
		send_number(32'h7FFF_FFFF, 6'd3);
		send_number(32'd9, 6'd10);
		send_number(32'd10, 6'd16);
		send_number(32'd15, 6'd16);
		send_number(32'd35, urad_pkg::BASE_MAX);
		send_number(32'd36, urad_pkg::BASE_MAX);
		send_number(32'd1234567890, 6'd10);
		send_number(32'hDEAD_BEEF, 6'd35);
		end_burst();
	endtask

	// radix outside 2..36 gives one flagged result and no digits; one good radix closes the test
	task automatic test_bad_radix();
		send_number(32'd0, 6'd0);
		send_number(32'hFFFF_FFFF, 6'd1);
		send_number(32'd123, urad_pkg::BASE_MAX + 6'd1);
		send_number(32'hFFFF_FFFF, 6'd63);
		send_number(32'd77, 6'd10);
		end_burst();
	endtask

	// receiver holds off long enough that the block fills and stalls its input
	task automatic test_output_stall();
		tx_idle_on = 1'b0;
		hold_left  = 1500;
		for (int i = 0; i < 6; i++) begin
			send_number($urandom, 6'd10);
		end
		tx_idle_on = 1'b1;
		end_burst();
	endtask

	// a few numbers, then a full drain before the next ones
	task automatic test_drain_pause();
		logic [urad_pkg::VALUE_W-1:0] val;
		logic [urad_pkg::BASE_W-1:0]  radix;
		for (int i = 0; i < 8; i++) begin
			random_number(val, radix);
			send_number(val, radix);
			if (i == 3) begin
				wait_all_done();
			end
		end
		end_burst();
	endtask

	task automatic test_random_numbers();
		logic [urad_pkg::VALUE_W-1:0] val;
		logic [urad_pkg::BASE_W-1:0]  radix;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			random_number(val, radix);
			send_number(val, radix);
		end
		end_burst();
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		logic [urad_pkg::VALUE_W-1:0] val;
		logic [urad_pkg::BASE_W-1:0]  radix;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 16; i++) begin
			random_number(val, radix);
			send_number(val, radix);
		end
		end_burst();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// result ready: forced hold-off first, then random stalls, else ready
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// compare every accepted character with the oldest one owed
	always @(posedge clk) begin
		radix_char_t want;
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h last %b bad_base %b",
					result_if.digit_char, result_if.last, result_if.bad_base));
			end else begin
				want = pending_chars.pop_front();
				if (result_if.digit_char !== want.digit_char || result_if.last !== want.last
						|| result_if.bad_base !== want.bad_base) begin
					report_mismatch($sformatf(
						"char exp %h got %h, last exp %b got %b, bad_base exp %b got %b",
						want.digit_char, result_if.digit_char, want.last, result_if.last,
						want.bad_base, result_if.bad_base));
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("tb_top: timeout with %0d characters still owed", pending_chars.size());
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		mismatches     = 0;
		numbers_sent   = 0;
		bad_radix_sent = 0;
		chars_checked  = 0;
		hold_left      = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		arst_n        <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.value <= '0;
		item_if.base  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_digit_extremes();
		test_bad_radix();
		test_output_stall();
		test_drain_pause();
		test_random_numbers();
		test_back_to_back();
		wait_all_done();

		$display("tb_top: %0d numbers converted (%0d with a bad radix), %0d characters checked",
			numbers_sent, bad_radix_sent, chars_checked);
		$display("tb_top: included a long output hold-off, a full drain and a stall-free stretch");
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: %0d mismatches", mismatches);
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// File: unsigned_to_ascii_radix_core.f
rtl/urad_pkg.sv
rtl/urad_if.sv
rtl/urad_div.sv
rtl/unsigned_to_ascii_radix_core.sv
test/tb_top.sv
